@@ rtl/core/radio_frame_receive_parser_defines.svh @@
// ---------------------------------------------------------------------------
// Frame receive parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef RADIO_FRAME_RECEIVE_PARSER_DEFINES_SVH
`define RADIO_FRAME_RECEIVE_PARSER_DEFINES_SVH

// Same-cycle implication
`define RFRP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rfrp: same-cycle check failed");

// Next-cycle implication
`define RFRP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rfrp: next-cycle check failed");

`endif

@@ rtl/core/rfrp_pkg.sv @@
// ---------------------------------------------------------------------------
// Frame receive parser package
// Types, header layout constants and the command decode shared by the
// parser modules.
// ---------------------------------------------------------------------------
package rfrp_pkg;

    localparam int BYTE_W             = 8;
    localparam int POS_W              = 8;
    localparam int HEADER_BYTES_DEF   = 8;
    localparam int CHECKSUM_BYTES_DEF = 2;

    localparam logic [POS_W-1:0] HDR_CMD_POS = 8'd3;
    localparam logic [POS_W-1:0] HDR_LEN_POS = 8'd5;

    localparam logic [BYTE_W-1:0] CMD_RX_DATA      = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_GET_CONFIG   = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_TELEMETRY    = 8'h07;
    localparam logic [BYTE_W-1:0] CMD_FIRMWARE_REV = 8'h0C;

    // Output stream layout
    localparam int OUT_DATA_BITS = 4 * BYTE_W + 2;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
    localparam int IN_TDATA_W    = BYTE_W;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_HEADER   = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_CHECKSUM = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_HEADER   = 2'd0,
        ROLE_PAYLOAD  = 2'd1,
        ROLE_CHECKSUM = 2'd2
    } t_role;

    typedef struct packed {
        t_role              role;
        logic [POS_W-1:0]   section_index;
        logic [BYTE_W-1:0]  data_byte;
        logic [BYTE_W-1:0]  frame_command;
        logic [BYTE_W-1:0]  frame_length;
        logic               header_done;
        logic               has_payload;
        logic               frame_done;
    } t_result;

    function automatic logic cmd_has_payload(input logic [BYTE_W-1:0] cmd);
        logic hit;
        begin
            unique case (cmd) inside
                CMD_RX_DATA, CMD_GET_CONFIG, CMD_TELEMETRY, CMD_FIRMWARE_REV: hit = 1'b1;
                default: hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

@@ rtl/core/rfrp_step.sv @@
// ---------------------------------------------------------------------------
// Frame receive parser step
// Holds phase, position, command and length; tags each accepted byte and
// advances the frame state in the same cycle.
// ---------------------------------------------------------------------------
`include "radio_frame_receive_parser_defines.svh"

module rfrp_step
    import rfrp_pkg::*;
#(
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
    parameter int CHECKSUM_BYTES = CHECKSUM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_result           o_result
);

    t_phase            r_phase,    n_phase;
    logic [POS_W-1:0]  r_position, n_position;
    logic [BYTE_W-1:0] r_command,  n_command;
    logic [BYTE_W-1:0] r_length,   n_length;

    logic [POS_W-1:0]  idx;
    logic [POS_W:0]    idx_inc;
    logic [BYTE_W-1:0] cmd_base;
    logic [BYTE_W-1:0] len_base;
    logic              hdr_done;
    logic              frm_done;
    t_role             role;

    always_comb begin
        idx        = (r_phase == PH_IDLE) ? '0 : r_position;
        idx_inc    = {1'b0, idx} + {{POS_W{1'b0}}, 1'b1};
        cmd_base   = (r_phase == PH_IDLE) ? '0 : r_command;
        len_base   = (r_phase == PH_IDLE) ? '0 : r_length;
        n_phase    = r_phase;
        n_position = r_position;
        n_command  = r_command;
        n_length   = r_length;
        hdr_done   = 1'b0;
        frm_done   = 1'b0;
        role       = ROLE_HEADER;
        unique case (r_phase) inside
            PH_IDLE, PH_HEADER: begin
                role      = ROLE_HEADER;
                n_command = (idx == HDR_CMD_POS) ? i_rx_byte : cmd_base;
                n_length  = (idx == HDR_LEN_POS) ? i_rx_byte : len_base;
                if (idx_inc >= (POS_W+1)'(HEADER_BYTES)) begin
                    hdr_done   = 1'b1;
                    n_position = '0;
                    if (cmd_has_payload(n_command)) begin
                        n_phase = (n_length == '0) ? PH_CHECKSUM : PH_PAYLOAD;
                    end else begin
                        n_phase  = PH_IDLE;
                        frm_done = 1'b1;
                    end
                end else begin
                    n_position = idx_inc[POS_W-1:0];
                    n_phase    = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                if (idx_inc >= {1'b0, r_length}) begin
                    n_position = '0;
                    n_phase    = PH_CHECKSUM;
                end else begin
                    n_position = idx_inc[POS_W-1:0];
                end
            end
            PH_CHECKSUM: begin
                role = ROLE_CHECKSUM;
                if (idx_inc >= (POS_W+1)'(CHECKSUM_BYTES)) begin
                    n_position = '0;
                    n_phase    = PH_IDLE;
                    frm_done   = 1'b1;
                end else begin
                    n_position = idx_inc[POS_W-1:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_result.role          = role;
        o_result.section_index = idx;
        o_result.data_byte     = i_rx_byte;
        o_result.frame_command = n_command;
        o_result.frame_length  = n_length;
        o_result.header_done   = hdr_done;
        o_result.has_payload   = cmd_has_payload(n_command);
        o_result.frame_done    = frm_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_position <= '0;
            r_command  <= '0;
            r_length   <= '0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_command  <= n_command;
            r_length   <= n_length;
        end
    end

    // A header that ends the frame must carry a command without payload
    `RFRP_ASSERT_IMPLY(a_hdr_end_no_payload, i_clk, i_rst_n,
        i_take && o_result.header_done && o_result.frame_done, !o_result.has_payload)
    `RFRP_ASSERT_IMPLY(a_payload_in_range, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_position < r_length)
    `RFRP_ASSERT_IMPLY(a_checksum_in_range, i_clk, i_rst_n,
        r_phase == PH_CHECKSUM, r_position < POS_W'(CHECKSUM_BYTES))
    `RFRP_ASSERT_NEXT(a_frame_end_to_idle, i_clk, i_rst_n,
        i_take && o_result.frame_done, r_phase == PH_IDLE && r_position == '0)

endmodule

@@ rtl/core/rfrp_out_buf.sv @@
// ---------------------------------------------------------------------------
// Frame receive parser output buffer
// Output register with a skid stage, so a request is taken every cycle
// while the downstream side keeps up and none is lost when it stalls.
// ---------------------------------------------------------------------------
module rfrp_out_buf
    import rfrp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            // output slot frees up: drain the skid first
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_result;
            end
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

@@ rtl/core/radio_frame_receive_parser.sv @@
// ---------------------------------------------------------------------------
// Radio frame receive parser
// Tags received serial bytes as header, payload or checksum bytes.
// ---------------------------------------------------------------------------
// Input stream: one received byte per request on s_axis tdata.
// Output stream: one tagged request per input byte; tuser carries the byte
// role (0 header, 1 payload, 2 checksum), tlast marks the byte that ends a
// frame, tdata carries index, byte, command, length and header flags.
// The header is HEADER_BYTES long, command at byte 3, length at byte 5.
// Commands 0x04, 0x05, 0x07 and 0x0C continue with length payload bytes and
// CHECKSUM_BYTES checksum bytes; other commands end the frame at the header.
// A byte accepted at an edge is registered in the output register, or in the
// skid stage while the output stalls. One byte is taken per cycle while the
// receiver keeps up; the frame state is updated on each accepted byte.
// Reset clears the frame state to await the first header byte and empties
// the output buffer. When the receiver stalls, one more request is held in
// the skid stage, then s_axis tready drops until the output drains.
// ---------------------------------------------------------------------------
module radio_frame_receive_parser
    import rfrp_pkg::*;
#(
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
    parameter int CHECKSUM_BYTES = CHECKSUM_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] section_index, [15:8] data_byte, [23:16] frame_command,
    // [31:24] frame_length, [32] header_done, [33] has_payload, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]             o_m_axis_tuser,  // [1:0] byte_role
    output logic                   o_m_axis_tlast   // frame_done
);

    logic    take;
    logic    buf_ready;
    t_result step_res;
    t_result out_res;

    assign take            = i_s_axis_tvalid && buf_ready;
    assign o_s_axis_tready = buf_ready;

    rfrp_step #(
        .HEADER_BYTES   (HEADER_BYTES),
        .CHECKSUM_BYTES (CHECKSUM_BYTES)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_s_axis_tdata[BYTE_W-1:0]),
        .o_result  (step_res)
    );

    rfrp_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (take),
        .i_result (step_res),
        .o_ready  (buf_ready),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-OUT_DATA_BITS){1'b0}},
                             out_res.has_payload,
                             out_res.header_done,
                             out_res.frame_length,
                             out_res.frame_command,
                             out_res.data_byte,
                             out_res.section_index};
    assign o_m_axis_tuser = out_res.role;
    assign o_m_axis_tlast = out_res.frame_done;

endmodule
